/* design/rpn_pkg.sv */
package rpn_pkg;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] operand;
    logic [4:0]  remove_count;
    logic [2:0]  operation;
  } rpn_in_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [4:0]  removed_count;
    logic [4:0]  space_left;
    logic [2:0]  status;
  } rpn_out_t;

  localparam logic [2:0] MODE_PUSH   = 3'd0;
  localparam logic [2:0] MODE_POP    = 3'd1;
  localparam logic [2:0] MODE_PEEK   = 3'd2;
  localparam logic [2:0] MODE_REMOVE = 3'd3;
  localparam logic [2:0] MODE_OPER   = 3'd4;
  localparam logic [2:0] MODE_SPACE  = 3'd5;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_SQRT = 3'd4;
  localparam logic [2:0] OP_MOD  = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FEW   = 3'd1;
  localparam logic [2:0] ST_OVF   = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_NEG   = 3'd4;
  localparam logic [2:0] ST_FULL  = 3'd5;

  // control from sequencer to the iterative unit
  typedef struct packed {
    logic       start;
    logic       is_sqrt;
  } rpn_iter_ctl_t;

endpackage

/* design/rpn_iter.sv */
// Shared restoring unit: one quotient or root bit per cycle on magnitudes.
module rpn_iter import rpn_pkg::*; #(
  parameter int W = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rpn_iter_ctl_t ctl_i,
  input  logic [W-1:0]  a_i,
  input  logic [W-1:0]  b_i,
  output logic          done_o,
  output logic [W-1:0]  q_o,
  output logic [W-1:0]  r_o
);
  localparam int CW = $clog2(W + 1);
  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          sqrt_q, sqrt_d;
  logic [W-1:0]  num_q, num_d, quo_q, quo_d, div_q, div_d;
  logic [W+1:0]  rem_q, rem_d;
  logic [W+1:0]  trial, shifted;
  logic          done_q, done_d;

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; sqrt_d = sqrt_q; num_d = num_q;
    quo_d = quo_q; div_d = div_q; rem_d = rem_q; done_d = 1'b0;
    shifted = '0; trial = '0;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      sqrt_d = ctl_i.is_sqrt;
      num_d  = a_i;
      div_d  = b_i;
      quo_d  = '0;
      rem_d  = '0;
      cnt_d  = sqrt_d ? CW'(W / 2) : CW'(W);
    end else if (busy_q) begin
      if (sqrt_q) begin
        shifted = {rem_q[W-1:0], num_q[W-1:W-2]};
        trial   = {quo_q[W-1:0], 2'b01};
        num_d   = {num_q[W-3:0], 2'b00};
      end else begin
        shifted = {rem_q[W:0], num_q[W-1]};
        trial   = {2'b00, div_q};
        num_d   = {num_q[W-2:0], 1'b0};
      end
      if (shifted >= trial) begin
        rem_d = shifted - trial;
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0; sqrt_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d; sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; div_q <= div_d; rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign q_o    = quo_q;
  assign r_o    = rem_q[W-1:0];

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("iter done while busy");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("iter count ran out while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("iter done held");
endmodule

/* design/rpn_stack_calculator_unit.sv */
// Channel  | Direction | Signals                          | Handshake
// command  | in        | start, cmd_i (rpn_in_t)          | start && !busy
// result   | out       | result_valid_o, result_o         | strobe, one cycle
// config   | in        | cfg_valid_i, cfg_ready_o, cfg_data_i | valid && ready
//
// Sequence: push, pop, peek, remove, query, add and subtract keep busy high
// through read (top two entries), compute and report states. Multiply adds a
// state on the multiplier; divide, modulo and square root add an iterate
// state on the one-bit-per-cycle restoring unit.
// A command wins over a config write offered in the same idle cycle.
// Reset empties the stack and sets the limit to STACK_DEPTH; stack
// contents stay undefined. The receiver cannot stall; results are strobed.
module rpn_stack_calculator_unit import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  rpn_in_t  cmd_i,
  output logic     result_valid_o,
  output rpn_out_t result_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic [4:0] cfg_data_i
);
  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ITER = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [PW-1:0] sp_q, sp_d, lim_q, lim_d;
  rpn_in_t       cmd_q;
  logic [W-1:0]  mem [STACK_DEPTH];
  logic [W-1:0]  x_q, y_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [W-1:0]  wr_data;
  rpn_out_t      res_d, res_q;
  logic          rv_q;
  logic [2*W-1:0] prod_q;
  logic          pneg_q;
  rpn_iter_ctl_t ictl;
  logic          idone;
  logic [W-1:0]  iq, ir, ia, ib;
  logic [W-1:0]  mx, my, sum, dif, r;
  logic [PW-1:0] cnt_eff, lim_eff;
  logic [W:0]    bound;
  logic          xs, ys;

  // clamp the remove count: zero or more than the depth drops all
  always_comb begin
    if (cmd_q.remove_count == 5'd0 || 32'(cmd_q.remove_count) > 32'(sp_q)) cnt_eff = sp_q;
    else cnt_eff = PW'(cmd_q.remove_count);
  end
  // limit register is already saturated to 1..STACK_DEPTH on write
  assign lim_eff = lim_q;

  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = state_q == S_IDLE && !start;

  // stack storage: read top two entries into registers
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    x_q <= mem[AW'(sp_q - PW'(2))];
    y_q <= mem[AW'(sp_q - PW'(1))];
  end

  assign xs = x_q[W-1];
  assign ys = y_q[W-1];
  assign mx = xs ? -x_q : x_q;
  assign my = ys ? -y_q : y_q;
  assign sum = x_q + y_q;
  assign dif = x_q - y_q;
  assign ictl.start   = state_q == S_EXEC && cmd_q.mode == MODE_OPER &&
                        ((cmd_q.operation == OP_SQRT && sp_q != '0 && !ys) ||
                         ((cmd_q.operation == OP_DIV || cmd_q.operation == OP_MOD)
                          && sp_q >= PW'(2) && y_q != '0));
  assign ictl.is_sqrt = cmd_q.operation == OP_SQRT;
  assign ia = ictl.is_sqrt ? y_q : mx;
  assign ib = my;

  rpn_iter #(.W(W)) u_iter (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ictl), .a_i(ia), .b_i(ib),
    .done_o(idone), .q_o(iq), .r_o(ir)
  );

  assign bound = pneg_q ? {1'b0, 1'b1, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};

  function automatic logic [31:0] ext(input logic [W-1:0] v);
    return 32'($signed(v));
  endfunction

  always_comb begin
    state_d = state_q; sp_d = sp_q; lim_d = lim_q;
    wr_en = 1'b0; wr_addr = AW'(sp_q - PW'(1)); wr_data = '0;
    res_d = '0; r = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_READ;
        end else if (cfg_valid_i) begin
          if (cfg_data_i == 5'd0) lim_d = PW'(1);
          else if (32'(cfg_data_i) > 32'(STACK_DEPTH)) lim_d = PW'(STACK_DEPTH);
          else lim_d = PW'(cfg_data_i);
          sp_d = '0;
        end
      end
      S_READ: state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_DONE;
        case (cmd_q.mode)
          MODE_PUSH: begin
            if (sp_q >= lim_eff) res_d.status = ST_FULL;
            else begin
              wr_en = 1'b1; wr_addr = AW'(sp_q);
              wr_data = W'($signed(cmd_q.operand));
              sp_d = sp_q + PW'(1);
            end
          end
          MODE_POP, MODE_PEEK: begin
            if (sp_q == '0) res_d.status = ST_FEW;
            else begin
              res_d.result_value = ext(y_q);
              if (cmd_q.mode == MODE_POP) sp_d = sp_q - PW'(1);
            end
          end
          MODE_REMOVE: begin
            res_d.removed_count = 5'(cnt_eff); sp_d = sp_q - cnt_eff;
          end
          MODE_OPER: begin
            case (cmd_q.operation)
              OP_SQRT: begin
                if (sp_q == '0) res_d.status = ST_FEW;
                else if (ys) begin
                  res_d.status = ST_NEG; sp_d = sp_q - PW'(1);
                end else state_d = S_ITER;
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                if (sp_q < PW'(2)) res_d.status = ST_FEW;
                else if (cmd_q.operation == OP_ADD) begin
                  if (xs == ys && sum[W-1] != xs) res_d.status = ST_OVF;
                  else r = sum;
                end else if (cmd_q.operation == OP_SUB) begin
                  if (xs != ys && dif[W-1] != xs) res_d.status = ST_OVF;
                  else r = dif;
                end else if (cmd_q.operation == OP_MUL) begin
                  state_d = S_MUL;
                end else begin
                  if (y_q == '0) res_d.status = ST_DIVZ;
                  else state_d = S_ITER;
                end
                if (res_d.status == ST_OK && (cmd_q.operation == OP_ADD ||
                    cmd_q.operation == OP_SUB)) begin
                  wr_en = 1'b1; wr_addr = AW'(sp_q - PW'(2)); wr_data = r;
                  sp_d = sp_q - PW'(1); res_d.result_value = ext(r);
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_MUL: begin
        state_d = S_DONE;
        if (prod_q[2*W-1:W] != '0 || {1'b0, prod_q[W-1:0]} > bound)
          res_d.status = ST_OVF;
        else begin
          r = pneg_q ? -prod_q[W-1:0] : prod_q[W-1:0];
          wr_en = 1'b1; wr_addr = AW'(sp_q - PW'(2)); wr_data = r;
          sp_d = sp_q - PW'(1); res_d.result_value = ext(r);
        end
      end
      S_ITER: begin
        if (idone) begin
          state_d = S_DONE;
          if (cmd_q.operation == OP_SQRT) r = iq;
          else if (cmd_q.operation == OP_DIV) r = (xs ^ ys) ? -iq : iq;
          else r = xs ? -ir : ir;
          if (cmd_q.operation == OP_SQRT) begin
            wr_en = 1'b1; wr_addr = AW'(sp_q - PW'(1));
          end else begin
            wr_en = 1'b1; wr_addr = AW'(sp_q - PW'(2)); sp_d = sp_q - PW'(1);
          end
          wr_data = r; res_d.result_value = ext(r);
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    res_d.space_left = 5'(lim_eff - sp_d);
  end

  logic fin;
  assign fin = (state_q == S_EXEC && state_d == S_DONE) ||
               (state_q == S_MUL) || (state_q == S_ITER && idone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; sp_q <= '0; lim_q <= PW'(STACK_DEPTH); rv_q <= 1'b0;
    end else begin
      state_q <= state_d; sp_q <= sp_d; lim_q <= lim_d; rv_q <= fin;
    end
  end

  // hold command, product and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) cmd_q <= cmd_i;
    prod_q <= mx * my;
    pneg_q <= (xs ^ ys) && (mx * my) != '0;
    if (fin) res_q <= res_d;
  end

  assign result_valid_o = rv_q;
  assign result_o       = res_q;

  a_sp_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= lim_q) else $error("stack pointer above limit");
  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> state_q == S_DONE) else $error("result outside done state");
  a_no_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !cfg_ready_o) else $error("config ready while busy");
endmodule

/* bench/rpn_stack_calculator_unit_tb.sv */
module rpn_stack_calculator_unit_tb;
  import rpn_pkg::*;

  localparam int DEPTH     = 16;
  localparam int IDLE_WAIT = 2000;

  // Mirrors the operand stack and compares each strobed result with the
  // oldest prediction.
  class rpn_scoreboard;
    logic [31:0] stk[DEPTH];
    int          depth;
    logic [4:0]  limit;
    rpn_out_t    pending[$];
    int          fails;

    function new();
      depth = 0;
      limit = 5'd16;
      fails = 0;
    endfunction

    // Writing the limit also empties the stack.
    function void set_limit(logic [4:0] v);
      limit = v;
      depth = 0;
    endfunction

    function int eff_limit();
      if (limit < 1) return 1;
      if (limit > DEPTH) return DEPTH;
      return limit;
    endfunction

    function int unsigned floor_root(int unsigned n);
      int unsigned r;
      longint      t;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
        t = longint'(r | (32'd1 << b));
        if (t * t <= longint'(n)) r = r | (32'd1 << b);
      end
      return r;
    endfunction

    function void note_input(rpn_in_t c);
      rpn_out_t    e;
      int          lim;
      int          cnt;
      longint      x;
      longint      y;
      longint      r;
      logic [2:0]  st;
      logic [31:0] v;
      e   = '0;
      st  = ST_OK;
      v   = '0;
      lim = eff_limit();
      if (depth > lim) depth = lim;
      case (c.mode)
        MODE_PUSH: begin
          if (depth >= lim) st = ST_FULL;
          else begin
            stk[depth] = c.operand;
            depth++;
          end
        end
        MODE_POP, MODE_PEEK: begin
          if (depth == 0) st = ST_FEW;
          else begin
            v = stk[depth-1];
            if (c.mode == MODE_POP) depth--;
          end
        end
        MODE_REMOVE: begin
          cnt = c.remove_count;
          if (cnt == 0 || cnt > depth) cnt = depth;
          depth -= cnt;
          e.removed_count = cnt[4:0];
        end
        MODE_OPER: begin
          if (c.operation == OP_SQRT) begin
            if (depth < 1) st = ST_FEW;
            else if (stk[depth-1][31]) begin
              // a negative root still consumes its operand
              depth--;
              st = ST_NEG;
            end else begin
              stk[depth-1] = floor_root(stk[depth-1]);
              v = stk[depth-1];
            end
          end else if (c.operation <= OP_MOD) begin
            if (depth < 2) st = ST_FEW;
            else begin
              x = longint'($signed(stk[depth-2]));
              y = longint'($signed(stk[depth-1]));
              r = 0;
              case (c.operation)
                OP_ADD: r = x + y;
                OP_SUB: r = x - y;
                OP_MUL: r = x * y;
                default: begin
                  // minimum over -1 wraps when truncated back to 32 bits
                  if (y == 0) st = ST_DIVZ;
                  else if (c.operation == OP_DIV) r = x / y;
                  else r = x % y;
                end
              endcase
              if (c.operation inside {OP_ADD, OP_SUB, OP_MUL} &&
                  (r > 64'sd2147483647 || r < -64'sd2147483648)) st = ST_OVF;
              if (st == ST_OK) begin
                depth--;
                stk[depth-1] = r[31:0];
                v = r[31:0];
              end
            end
          end
        end
        default: ;
      endcase
      e.result_value = (st == ST_OK) ? v : '0;
      e.space_left   = 5'(lim - depth);
      e.status       = st;
      pending.push_back(e);
    endfunction

    function void check(rpn_out_t got);
      rpn_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (got.result_value !== e.result_value) begin
        $error("result_value: expected %0d, got %0d",
               $signed(e.result_value), $signed(got.result_value));
        fails++;
      end
      if (got.removed_count !== e.removed_count) begin
        $error("removed_count: expected %0d, got %0d", e.removed_count, got.removed_count);
        fails++;
      end
      if (got.space_left !== e.space_left) begin
        $error("space_left: expected %0d, got %0d", e.space_left, got.space_left);
        fails++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        fails++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  rpn_in_t    cmd_i = '0;
  logic       result_valid_o;
  rpn_out_t   result_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [4:0] cfg_data_i = '0;

  rpn_scoreboard sb = new();
  bit            quiet;
  int            stalled;

  always #4 clk_i = ~clk_i;

  rpn_stack_calculator_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // Note accepted commands before checking results; a result always trails
  // its command. Count idle cycles for the watchdog.
  always @(posedge clk_i) begin : monitor
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        sb.note_input(cmd_i);
        moved = 1'b1;
      end
      if (result_valid_o) begin
        sb.check(result_o);
        moved = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) moved = 1'b1;
      if (moved) stalled <= 0;
      else stalled <= stalled + 1;
      if (stalled >= IDLE_WAIT) begin
        $display("rpn_stack_calculator_unit test failed");
        $finish;
      end
    end else begin
      stalled <= 0;
    end
  end

  function automatic rpn_in_t mk(logic [2:0] m, logic [31:0] val, logic [4:0] cnt,
                                 logic [2:0] op);
    rpn_in_t c;
    c.mode         = m;
    c.operand      = val;
    c.remove_count = cnt;
    c.operation    = op;
    return c;
  endfunction

  // Drive one command and hold it until taken; then maybe drop start a while.
  task automatic send(rpn_in_t c);
    cmd_i <= c;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (!quiet && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Write the limit only once every result is back and the unit is idle.
  task automatic write_limit(logic [4:0] v);
    start <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (45) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_limit(v);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 40)) - 32'd20;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          default: return 32'h0000_ffff;
        endcase
      end
      2: return $urandom();
      default: return 32'($urandom_range(0, 140000)) - 32'd70000;
    endcase
  endfunction

  // Mostly pushes and operations so the stack fills and drains; the rest
  // exercise pop, peek, remove, space queries and unused codes.
  function automatic rpn_in_t rand_cmd();
    int         w;
    logic [2:0] m;
    w = $urandom_range(0, 99);
    if (w < 38) m = MODE_PUSH;
    else if (w < 66) m = MODE_OPER;
    else if (w < 73) m = MODE_POP;
    else if (w < 79) m = MODE_PEEK;
    else if (w < 86) m = MODE_REMOVE;
    else if (w < 94) m = MODE_SPACE;
    else m = 3'($urandom_range(6, 7));
    return mk(m, rand_value(), 5'($urandom_range(0, 31)),
              ($urandom_range(0, 99) < 95) ? 3'($urandom_range(0, 5))
                                           : 3'($urandom_range(6, 7)));
  endfunction

  initial begin
    logic [4:0] limits[7];
    limits = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2, 5'd16};
    quiet = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stack, overflow, divide by zero, wrap, negative root, unused codes
    send(mk(MODE_POP, '0, '0, OP_ADD));
    send(mk(MODE_PEEK, '0, '0, OP_ADD));
    send(mk(MODE_OPER, '0, '0, OP_ADD));
    send(mk(MODE_OPER, '0, '0, OP_SQRT));
    send(mk(MODE_PUSH, 32'h7fff_ffff, '0, OP_ADD));
    send(mk(MODE_PUSH, 32'd1, '0, OP_ADD));
    send(mk(MODE_OPER, '0, '0, OP_ADD));
    send(mk(MODE_OPER, '0, '0, OP_MUL));
    send(mk(MODE_PUSH, 32'h8000_0000, '0, OP_ADD));
    send(mk(MODE_PUSH, 32'hffff_ffff, '0, OP_ADD));
    send(mk(MODE_OPER, '0, '0, OP_DIV));
    send(mk(MODE_PUSH, 32'hffff_ffff, '0, OP_ADD));
    send(mk(MODE_OPER, '0, '0, OP_MOD));
    send(mk(MODE_PUSH, 32'd0, '0, OP_ADD));
    send(mk(MODE_OPER, '0, '0, OP_DIV));
    send(mk(MODE_OPER, '0, '0, OP_MOD));
    send(mk(MODE_OPER, '0, '0, OP_SUB));
    send(mk(MODE_PUSH, 32'hffff_fffb, '0, OP_ADD));
    send(mk(MODE_OPER, '0, '0, OP_SQRT));
    send(mk(MODE_PUSH, 32'h7fff_ffff, '0, OP_ADD));
    send(mk(MODE_OPER, '0, '0, OP_SQRT));
    send(mk(MODE_OPER, '0, '0, 3'd6));
    send(mk(3'd7, '0, '0, OP_ADD));
    send(mk(MODE_SPACE, '0, '0, OP_ADD));
    send(mk(MODE_REMOVE, '0, 5'd0, OP_ADD));

    // one phase per limit setting, the fourth without any idling
    foreach (limits[p]) begin
      write_limit(limits[p]);
      quiet = (p == 3);
      repeat (175) send(rand_cmd());
    end
    quiet = 1'b0;

    start <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (50) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("rpn_stack_calculator_unit test passed");
    end else begin
      $display("rpn_stack_calculator_unit test failed");
    end
    $finish;
  end

endmodule
